// File: rtl/gbt_pkg.sv
// Package for the GB18030 boundary truncator: widths, codes and shared types.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package gbt_pkg;

	// Width of the committed byte count; the total count is one bit wider.
	localparam int COUNT_W = 16;
	localparam int LIMIT_W = 16;
	localparam int KEPT_W  = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Word index of the byte limit register within the APB space.
	localparam logic REG_BYTE_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		CAUSE_FIT   = 2'd0,
		CAUSE_LIMIT = 2'd1,
		CAUSE_BAD   = 2'd2
	} cause_t;

	// Place within the current character.
	typedef enum logic [3:0] {
		POS_LEAD   = 4'b0001,
		POS_SECOND = 4'b0010,
		POS_THIRD  = 4'b0100,
		POS_FOURTH = 4'b1000
	} pos_t;

	typedef struct packed {
		logic [KEPT_W-1:0] kept_length;
		cause_t            stop_cause;
	} result_t;

	// The limit is clipped to the largest value the committed count can hold.
	function automatic logic [COUNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] raw);
		logic [32:0] wide;
		logic [32:0] cap_m1;
		wide   = 33'(raw);
		cap_m1 = (33'(1) << COUNT_W) - 33'(1);
		if (wide > cap_m1) begin
			wide = cap_m1;
		end
		return wide[COUNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/gbt_if.sv
// Valid/ready channel interfaces for the byte stream and the result stream.
// Depends on gbt_pkg for field widths.
`default_nettype none
interface gbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_last;

	modport source (output valid, output data_byte, output is_last, input ready);
	modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface gbt_result_if import gbt_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [KEPT_W-1:0] kept_length;
	logic [1:0]        stop_cause;

	modport source (output valid, output kept_length, output stop_cause, input ready);
	modport sink   (input valid, input kept_length, input stop_cause, output ready);
endinterface
`default_nettype wire

// File: rtl/gbt_cfg.sv
// APB register file holding the byte limit.
// Depends on gbt_pkg for address and data widths.
`default_nettype none
module gbt_cfg import gbt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic      [LIMIT_W-1:0] byte_limit
);
	logic [LIMIT_W-1:0] limit_q;
	logic               sel_limit;

	assign sel_limit = (paddr[PADDR_W-1:2] == REG_BYTE_LIMIT);
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (psel && penable && pwrite && sel_limit) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata = PDATA_W'(limit_q);
		end
	end

	assign byte_limit = limit_q;
endmodule
`default_nettype wire

// File: rtl/gbt_scan.sv
// Per-string scan state: classifies GB18030 characters and tracks counts.
// Depends on gbt_pkg for codes, widths and the limit clipping function.
`default_nettype none
module gbt_scan import gbt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         data_byte,
	input  wire logic               is_last,
	input  wire logic [LIMIT_W-1:0] byte_limit,
	output logic                    push,
	output result_t                 result
);
	localparam logic [COUNT_W:0] TOTAL_CAP = (COUNT_W+1)'(1) << COUNT_W;

	logic [COUNT_W:0]   total_q,  total_n;
	logic [COUNT_W-1:0] comm_q,   comm_n;
	pos_t               pos_q,    pos_n;
	logic               stop_q,   stop_n;
	cause_t             cause_q,  cause_n;

	logic [COUNT_W-1:0] limit;
	logic               fin;
	logic [2:0]         size;
	logic [COUNT_W:0]   grown;
	logic [32:0]        kept_wide;

	assign limit = eff_limit(byte_limit);

	always_comb begin
		total_n = (total_q < TOTAL_CAP) ? total_q + (COUNT_W+1)'(1) : total_q;
		comm_n  = comm_q;
		pos_n   = pos_q;
		stop_n  = stop_q;
		cause_n = cause_q;
		fin     = 1'b0;
		size    = 3'd1;
		if (!stop_q) begin
			case (pos_q)
				POS_LEAD: begin
					if (data_byte inside {[8'h81:8'hFE]}) begin
						pos_n = POS_SECOND;
					end else begin
						fin  = 1'b1;
						size = 3'd1;
					end
				end
				POS_SECOND: begin
					if (data_byte inside {[8'h40:8'h7E], [8'h80:8'hFE]}) begin
						fin  = 1'b1;
						size = 3'd2;
					end else if (data_byte inside {[8'h30:8'h39]}) begin
						pos_n = POS_THIRD;
					end else begin
						stop_n  = 1'b1;
						cause_n = CAUSE_BAD;
					end
				end
				POS_THIRD: begin
					if (data_byte inside {[8'h81:8'hFE]}) begin
						pos_n = POS_FOURTH;
					end else begin
						stop_n  = 1'b1;
						cause_n = CAUSE_BAD;
					end
				end
				default: begin
					if (data_byte inside {[8'h30:8'h39]}) begin
						fin  = 1'b1;
						size = 3'd4;
					end else begin
						stop_n  = 1'b1;
						cause_n = CAUSE_BAD;
					end
				end
			endcase
		end
		grown = {1'b0, comm_q} + (COUNT_W+1)'(size);
		// A whole character is committed only if it still fits the limit.
		if (fin) begin
			if (grown > {1'b0, limit}) begin
				stop_n  = 1'b1;
				cause_n = CAUSE_LIMIT;
			end else begin
				comm_n = grown[COUNT_W-1:0];
				pos_n  = POS_LEAD;
			end
		end
	end

	always_comb begin
		if (total_n <= {1'b0, limit}) begin
			kept_wide         = 33'(total_n);
			result.stop_cause = CAUSE_FIT;
		end else begin
			kept_wide = 33'(comm_n);
			if (stop_n) begin
				result.stop_cause = cause_n;
			end else if (pos_n != POS_LEAD) begin
				result.stop_cause = CAUSE_BAD;
			end else begin
				result.stop_cause = CAUSE_LIMIT;
			end
		end
		result.kept_length = kept_wide[KEPT_W-1:0];
	end

	assign push = accept && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			comm_q  <= '0;
			pos_q   <= POS_LEAD;
			stop_q  <= 1'b0;
			cause_q <= CAUSE_FIT;
		end else if (accept) begin
			if (is_last) begin
				total_q <= '0;
				comm_q  <= '0;
				pos_q   <= POS_LEAD;
				stop_q  <= 1'b0;
				cause_q <= CAUSE_FIT;
			end else begin
				total_q <= total_n;
				comm_q  <= comm_n;
				pos_q   <= pos_n;
				stop_q  <= stop_n;
				cause_q <= cause_n;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> total_q == '0 && comm_q == '0 && !stop_q && pos_q == POS_LEAD)
		else $error("scan state not cleared after the last beat of a string");

	a_comm_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, comm_q} <= total_q)
		else $error("committed count exceeds the total count");

	a_pos_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(pos_q))
		else $error("character position lost its one-hot code");

	a_stop_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> (cause_q == CAUSE_LIMIT || cause_q == CAUSE_BAD))
		else $error("scan stopped without a recorded cause");
endmodule
`default_nettype wire

// File: rtl/gbt_out.sv
// Result register that drives the output channel and decouples the two sides.
// Depends on gbt_pkg for the result type and gbt_if for the channel.
`default_nettype none
module gbt_out import gbt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  result_t      result,
	output logic         in_ready,
	gbt_result_if.source res
);
	logic    valid_q;
	result_t data_q;

	// A new beat may enter while the held result is taken in the same cycle.
	assign in_ready = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= result;
		end
	end

	assign res.valid       = valid_q;
	assign res.kept_length = data_q.kept_length;
	assign res.stop_cause  = data_q.stop_cause;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!valid_q || res.ready))
		else $error("result overwritten before it was taken");
endmodule
`default_nettype wire

// File: rtl/gb18030_boundary_truncator.sv
// Top level of the GB18030 boundary truncator: APB register, scan and result stage.
// Depends on gbt_pkg, gbt_if, gbt_cfg, gbt_scan and gbt_out.
//
// The block takes one byte beat per clock cycle on the chars channel, with
// is_last on the final byte of a string, and gives one result beat per string:
// kept_length, the number of leading bytes that form whole GB18030 characters
// within byte_limit (or the whole string when it fits), and stop_cause
// (0 fits, 1 limit, 2 bad or cut-off sequence). Each byte is classified and
// the counts updated in the cycle it is accepted; the result appears in the
// output register on the cycle after the last byte is accepted. Throughput is
// one byte per cycle; input stalls only while a result waits and is not being
// taken. byte_limit sits at byte address 0; the user must write it only
// between strings, and the block itself does not enforce this.
`default_nettype none
module gb18030_boundary_truncator import gbt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	gbt_byte_if.sink                chars,
	gbt_result_if.source            result
);
	logic [LIMIT_W-1:0] byte_limit;
	logic               accept;
	logic               push;
	logic               in_ready;
	result_t            res_data;

	gbt_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.byte_limit (byte_limit)
	);

	assign chars.ready = in_ready;
	assign accept      = chars.valid && in_ready;

	gbt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (chars.data_byte),
		.is_last    (chars.is_last),
		.byte_limit (byte_limit),
		.push       (push),
		.result     (res_data)
	);

	gbt_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.result   (res_data),
		.in_ready (in_ready),
		.res      (result)
	);
endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for gb18030_boundary_truncator: directed and random strings checked against a predictor.
// Depends on gbt_pkg, the gbt_if channel interfaces and the block's RTL.
module tb_top;
	import gbt_pkg::*;

	localparam logic [7:0] LEAD_LO   = 8'h81;
	localparam logic [7:0] LEAD_HI   = 8'hFE;
	localparam logic [7:0] DIGIT_LO  = 8'h30;
	localparam logic [7:0] DIGIT_HI  = 8'h39;
	localparam logic [7:0] TRAIL_LO  = 8'h40;
	localparam logic [7:0] TRAIL_GAP = 8'h7F;
	localparam logic [7:0] ASCII_A   = 8'h41;
	localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(REG_BYTE_LIMIT) << 2;
	localparam int HOLD_CYCLES = 250;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	gbt_byte_if   chars_if ();
	gbt_result_if res_if ();

	gb18030_boundary_truncator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.chars   (chars_if),
		.result  (res_if)
	);

	int error_count = 0;
	int src_idle    = 0;
	int snk_idle    = 0;
	int hold_left   = 0;
	bit hold_start  = 1'b0;

	// Predictor state: a copy of the block's per-string scan state and the limit.
	logic [LIMIT_W-1:0] limit_reg;
	logic [COUNT_W:0]   seen_count;
	logic [COUNT_W-1:0] kept_count;
	pos_t               char_pos;
	bit                 halted;
	cause_t             halt_cause;

	result_t     pending_results[$];
	logic [7:0]  str_bytes[$];

	always #10 clk = ~clk;

	function automatic longint clipped_limit();
		longint lim;
		longint cap;
		lim = limit_reg;
		cap = (longint'(1) << COUNT_W) - 1;
		if (lim > cap) begin
			lim = cap;
		end
		return lim;
	endfunction

	function void clear_scan();
		seen_count = '0;
		kept_count = '0;
		char_pos   = POS_LEAD;
		halted     = 1'b0;
		halt_cause = CAUSE_FIT;
	endfunction

	function void halt_scan(cause_t c);
		halted     = 1'b1;
		halt_cause = c;
	endfunction

	function void commit_char(int size);
		if (longint'(kept_count) + size > clipped_limit()) begin
			halt_scan(CAUSE_LIMIT);
		end else begin
			kept_count = kept_count + COUNT_W'(size);
			char_pos   = POS_LEAD;
		end
	endfunction

	function void classify_byte(logic [7:0] b);
		case (char_pos)
			POS_LEAD: begin
				if (b < LEAD_LO || b > LEAD_HI) begin
					commit_char(1);
				end else begin
					char_pos = POS_SECOND;
				end
			end
			POS_SECOND: begin
				if ((b >= TRAIL_LO && b < TRAIL_GAP) || (b > TRAIL_GAP && b <= LEAD_HI)) begin
					commit_char(2);
				end else if (b >= DIGIT_LO && b <= DIGIT_HI) begin
					char_pos = POS_THIRD;
				end else begin
					halt_scan(CAUSE_BAD);
				end
			end
			POS_THIRD: begin
				if (b >= LEAD_LO && b <= LEAD_HI) begin
					char_pos = POS_FOURTH;
				end else begin
					halt_scan(CAUSE_BAD);
				end
			end
			default: begin
				if (b >= DIGIT_LO && b <= DIGIT_HI) begin
					commit_char(4);
				end else begin
					halt_scan(CAUSE_BAD);
				end
			end
		endcase
	endfunction

	// Advances the predictor by one accepted byte; the final byte queues the expected result.
	function void predict_truncation(logic [7:0] b, logic last);
		result_t r;
		if (seen_count < ((COUNT_W+1)'(1) << COUNT_W)) begin
			seen_count = seen_count + 1'b1;
		end
		if (!halted) begin
			classify_byte(b);
		end
		if (last) begin
			if (longint'(seen_count) <= clipped_limit()) begin
				r.kept_length = KEPT_W'(seen_count);
				r.stop_cause  = CAUSE_FIT;
			end else begin
				r.kept_length = KEPT_W'(kept_count);
				if (halted) begin
					r.stop_cause = halt_cause;
				end else if (char_pos != POS_LEAD) begin
					r.stop_cause = CAUSE_BAD;
				end else begin
					r.stop_cause = CAUSE_LIMIT;
				end
			end
			pending_results.push_back(r);
			clear_scan();
		end
	endfunction

	// Result beats are checked before the byte of the same edge is predicted.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: kept_length %0d stop_cause %0d",
						$time, res_if.kept_length, res_if.stop_cause);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (res_if.kept_length !== want.kept_length) begin
						$display("%0t: kept_length expected %0d actual %0d",
							$time, want.kept_length, res_if.kept_length);
						error_count++;
					end
					if (res_if.stop_cause !== want.stop_cause) begin
						$display("%0t: stop_cause expected %0d actual %0d",
							$time, want.stop_cause, res_if.stop_cause);
						error_count++;
					end
				end
			end
			if (chars_if.valid && chars_if.ready) begin
				predict_truncation(chars_if.data_byte, chars_if.is_last);
			end
		end
	end

	// Receiver: random stalls, or a long hold-off counted here when one is requested.
	always @(negedge clk) begin
		if (hold_start) begin
			hold_left  = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// Called and returns at a falling edge.
	task send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.data_byte <= b;
		chars_if.is_last   <= last;
		@(posedge clk);
		while (!chars_if.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task send_string();
		for (int i = 0; i < str_bytes.size(); i++) begin
			send_byte(str_bytes[i], i == str_bytes.size() - 1);
		end
		str_bytes.delete();
	endtask

	task wait_idle();
		chars_if.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	// Writes byte_limit, then reads it back.
	task write_limit(input logic [LIMIT_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		limit_reg = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata !== PDATA_W'(value)) begin
			$display("%0t: byte_limit readback expected %0d actual %0d", $time, value, prdata);
			error_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task add_bytes(input logic [7:0] a, input logic [7:0] b = 0, input logic [7:0] c = 0,
			input logic [7:0] d = 0, input logic [7:0] e = 0, input int n = 1);
		logic [7:0] v[5];
		v = '{a, b, c, d, e};
		for (int i = 0; i < n; i++) begin
			str_bytes.push_back(v[i]);
		end
	endtask

	function void append_char();
		int r;
		r = $urandom_range(19);
		if (r < 5) begin
			str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h80)) : 8'hFF);
		end else if (r < 10) begin
			str_bytes.push_back(8'($urandom_range(LEAD_LO, LEAD_HI)));
			str_bytes.push_back($urandom_range(1) ? 8'($urandom_range(TRAIL_LO, TRAIL_GAP - 1))
				: 8'($urandom_range(TRAIL_GAP + 1, LEAD_HI)));
		end else if (r < 16) begin
			str_bytes.push_back(8'($urandom_range(LEAD_LO, LEAD_HI)));
			str_bytes.push_back(8'($urandom_range(DIGIT_LO, DIGIT_HI)));
			str_bytes.push_back(8'($urandom_range(LEAD_LO, LEAD_HI)));
			str_bytes.push_back(8'($urandom_range(DIGIT_LO, DIGIT_HI)));
		end else if (r < 18) begin
			// Broken sequence: a lead byte followed by anything.
			str_bytes.push_back(8'($urandom_range(LEAD_LO, LEAD_HI)));
			str_bytes.push_back(8'($urandom_range(255)));
		end else begin
			str_bytes.push_back(8'($urandom_range(255)));
		end
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			default: return LIMIT_W'($urandom_range(1, 24));
		endcase
	endfunction

	task test_zero_limit();
		wait_idle();
		write_limit('0);
		add_bytes(8'h00);
		send_string();
		add_bytes(8'hFF);
		send_string();
		// A lone lead byte is cut off at the end.
		add_bytes(LEAD_LO);
		send_string();
	endtask

	task test_small_limit();
		wait_idle();
		write_limit(LIMIT_W'(3));
		// Bad second byte, but the whole string fits.
		add_bytes(LEAD_LO, TRAIL_GAP, ASCII_A, .n(3));
		send_string();
		// A valid four-byte character that crosses the limit.
		add_bytes(LEAD_LO, DIGIT_LO, LEAD_LO, DIGIT_LO, .n(4));
		send_string();
		// Bad fourth byte where the character would also cross the limit.
		add_bytes(ASCII_A, LEAD_HI, DIGIT_HI, LEAD_HI, DIGIT_LO - 1, .n(5));
		send_string();
		add_bytes(8'h80, LEAD_HI, 8'h80, ASCII_A, .n(4));
		send_string();
	endtask

	task test_full_limit();
		wait_idle();
		write_limit('1);
		add_bytes(LEAD_HI, LEAD_HI, .n(2));
		send_string();
		add_bytes(LEAD_HI, DIGIT_HI, LEAD_HI, DIGIT_HI, .n(4));
		send_string();
	endtask

	task test_random_strings(input int blocks, input int bytes_per_block);
		int sent;
		int n_chars;
		for (int k = 0; k < blocks; k++) begin
			wait_idle();
			write_limit(pick_limit());
			sent = 0;
			while (sent < bytes_per_block) begin
				n_chars = ($urandom_range(7) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
				for (int c = 0; c < n_chars; c++) begin
					append_char();
				end
				sent += str_bytes.size();
				send_string();
			end
		end
	endtask

	// The receiver stops for a long stretch while short strings keep coming.
	task test_result_backpressure();
		wait_idle();
		write_limit(LIMIT_W'(2));
		hold_start = 1'b1;
		for (int s = 0; s < 30; s++) begin
			append_char();
			send_string();
		end
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		chars_if.valid     = 1'b0;
		chars_if.data_byte = '0;
		chars_if.is_last   = 1'b0;
		res_if.ready       = 1'b0;
		limit_reg          = '0;
		clear_scan();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle = 29;
		snk_idle = 76;
		test_zero_limit();
		test_small_limit();
		test_full_limit();
		test_random_strings(4, 40);
		src_idle = 76;
		snk_idle = 29;
		test_random_strings(4, 40);
		src_idle = 0;
		snk_idle = 0;
		test_random_strings(4, 40);
		test_result_backpressure();

		wait_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout", $time);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
